// File: rtl/gfftc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfftc_pkg
// Shared types and constants of the grid flood-fill target counter.
// ----------------------------------------------------------------------------
package gfftc_pkg;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int COUNT_W   = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;
  localparam logic [CFG_W-1:0]     CFG_DIM_RESET = 7'd64;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

  localparam logic [1:0] KIND_BLOCKED = 2'd0;
  localparam logic [1:0] KIND_START   = 2'd2;
  localparam logic [1:0] KIND_TARGET  = 2'd3;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_POP,
    ST_POPW,
    ST_REM,
    ST_CUR,
    ST_CURW,
    ST_NB,
    ST_NBW,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    DIR_DOWN,
    DIR_UP,
    DIR_RIGHT,
    DIR_LEFT
  } dir_t;

  function automatic dir_t next_dir(input dir_t d);
    dir_t n;
    case (d)
      DIR_DOWN:  n = DIR_UP;
      DIR_UP:    n = DIR_RIGHT;
      DIR_RIGHT: n = DIR_LEFT;
      default:   n = DIR_DOWN;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// File: rtl/grid_flood_fill_target_counter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_flood_fill_target_counter_core
// Loads a classified grid one cell per cycle, then runs a multi-source BFS
// over a cell/visited RAM and a frontier-queue RAM and reports target hits.
// ----------------------------------------------------------------------------
// Throughput: one cell per cycle while loading (busy low); results cannot stall.
// Last cell: busy stays high while the fill pops each queued entry, reads its
//   cell and probes its in-bounds neighbors in turn; a start cell first has
//   its column recovered serially, and an entry outside the grid is skipped.
//   done pulses in the last busy cycle.
// Reset clears control state and sets both dimensions to 64; RAMs are not
//   cleared (every entry used by a fill is written during its load).
// ----------------------------------------------------------------------------
module grid_flood_fill_target_counter_core #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          cell_kind,
  input  wire logic                                last_cell,
  output logic                                     done,
  output logic      [gfftc_pkg::COUNT_W-1:0]       target_count,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [gfftc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gfftc_pkg::CFG_W-1:0]         cfg_data
);

  localparam int CAP = MAX_ROWS * MAX_COLS;
  localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int PW  = $clog2(CAP + 1);
  localparam int SW  = PW + 1;
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int CW1 = $clog2(MAX_COLS + 1);
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int QW  = CW + AW;
  localparam logic [PW-1:0] CAP_P = PW'(CAP);

  gfftc_pkg::state_t state, state_next;
  gfftc_pkg::dir_t   dir;

  logic [gfftc_pkg::CFG_W-1:0] rows_reg, cols_reg;
  logic [RW-1:0]  rows_c;
  logic [CW1-1:0] cols_c;
  logic [RW+CW1-1:0] prod;

  logic [PW-1:0] load_pos, head, tail, seed_end, limit;
  logic [gfftc_pkg::COUNT_W-1:0] count;
  logic [AW-1:0] cur_p, nb_p;
  logic [CW-1:0] cur_c, nb_c;
  logic          seed;

  // RAM ports
  logic          c_we, c_re;
  logic [AW-1:0] c_waddr, c_raddr;
  logic [2:0]    c_wdata, c_rdata;
  logic          q_we, q_re;
  logic [AW-1:0] q_waddr, q_raddr;
  logic [QW-1:0] q_wdata, q_rdata;

  logic          rem_start, rem_done;
  logic [CW1-1:0] rem_value;

  logic          accept, load_ok;
  logic          nb_ok;
  logic [SW-1:0] p_s, cols_s, lim_s, np_s;
  logic [CW-1:0] nc;
  logic [AW-1:0] q_p;
  logic          enter;

  assign accept    = start && !busy;
  assign load_ok   = load_pos < CAP_P;
  // geometry stays fixed while a fill runs
  assign cfg_ready = !busy;
  assign q_p       = q_rdata[AW-1:0];
  assign enter     = (c_rdata[1:0] != gfftc_pkg::KIND_BLOCKED) && !c_rdata[2];

  always_comb begin
    if (rows_reg == '0) begin
      rows_c = RW'(1);
    end else if (32'(rows_reg) > MAX_ROWS) begin
      rows_c = RW'(MAX_ROWS);
    end else begin
      rows_c = RW'(rows_reg);
    end
    if (cols_reg == '0) begin
      cols_c = CW1'(1);
    end else if (32'(cols_reg) > MAX_COLS) begin
      cols_c = CW1'(MAX_COLS);
    end else begin
      cols_c = CW1'(cols_reg);
    end
  end

  assign prod = (RW+CW1)'(rows_c) * (RW+CW1)'(cols_c);

  // Neighbor address and bounds for the current direction
  always_comb begin
    p_s    = SW'(cur_p);
    cols_s = SW'(cols_c);
    lim_s  = SW'(limit);
    case (dir)
      gfftc_pkg::DIR_DOWN: begin
        np_s  = p_s + cols_s;
        nb_ok = np_s < lim_s;
        nc    = cur_c;
      end
      gfftc_pkg::DIR_UP: begin
        np_s  = p_s - cols_s;
        nb_ok = p_s >= cols_s;
        nc    = cur_c;
      end
      gfftc_pkg::DIR_RIGHT: begin
        np_s  = p_s + SW'(1);
        nb_ok = ((CW1'(cur_c) + CW1'(1)) < cols_c) && (np_s < lim_s);
        nc    = cur_c + CW'(1);
      end
      default: begin
        np_s  = p_s - SW'(1);
        nb_ok = cur_c != '0;
        nc    = cur_c - CW'(1);
      end
    endcase
  end

  // Next state and RAM port control
  always_comb begin
    state_next = state;
    busy       = 1'b1;
    done       = 1'b0;
    c_we = 1'b0; c_waddr = load_pos[AW-1:0]; c_wdata = {cell_kind == gfftc_pkg::KIND_START,
                                                        cell_kind};
    c_re = 1'b0; c_raddr = cur_p;
    q_we = 1'b0; q_waddr = tail[AW-1:0]; q_wdata = {CW'(0), load_pos[AW-1:0]};
    q_re = 1'b0; q_raddr = head[AW-1:0];
    rem_start = 1'b0;
    case (state)
      gfftc_pkg::ST_LOAD: begin
        busy = 1'b0;
        if (accept) begin
          c_we = load_ok;
          q_we = load_ok && (cell_kind == gfftc_pkg::KIND_START) && (tail < CAP_P);
          if (last_cell) state_next = gfftc_pkg::ST_INIT;
        end
      end
      gfftc_pkg::ST_INIT: state_next = gfftc_pkg::ST_POP;
      gfftc_pkg::ST_POP: begin
        if (head == tail) begin
          state_next = gfftc_pkg::ST_DONE;
        end else begin
          q_re = 1'b1;
          state_next = gfftc_pkg::ST_POPW;
        end
      end
      gfftc_pkg::ST_POPW: begin
        if (PW'(q_p) >= limit) begin
          state_next = gfftc_pkg::ST_POP;
        end else if (seed) begin
          rem_start  = 1'b1;
          state_next = gfftc_pkg::ST_REM;
        end else begin
          state_next = gfftc_pkg::ST_CUR;
        end
      end
      gfftc_pkg::ST_REM: if (rem_done) state_next = gfftc_pkg::ST_CUR;
      gfftc_pkg::ST_CUR: begin
        c_re = 1'b1;
        state_next = gfftc_pkg::ST_CURW;
      end
      gfftc_pkg::ST_CURW: state_next = gfftc_pkg::ST_NB;
      gfftc_pkg::ST_NB: begin
        if (nb_ok) begin
          c_re    = 1'b1;
          c_raddr = np_s[AW-1:0];
          state_next = gfftc_pkg::ST_NBW;
        end else if (dir == gfftc_pkg::DIR_LEFT) begin
          state_next = gfftc_pkg::ST_POP;
        end
      end
      gfftc_pkg::ST_NBW: begin
        c_waddr = nb_p;
        c_wdata = {1'b1, c_rdata[1:0]};
        q_wdata = {nb_c, nb_p};
        if (enter) begin
          c_we = 1'b1;
          q_we = tail < CAP_P;
        end
        state_next = (dir == gfftc_pkg::DIR_LEFT) ? gfftc_pkg::ST_POP : gfftc_pkg::ST_NB;
      end
      gfftc_pkg::ST_DONE: begin
        done = 1'b1;
        state_next = gfftc_pkg::ST_LOAD;
      end
      default: state_next = gfftc_pkg::ST_LOAD;
    endcase
  end

  assign target_count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gfftc_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_reg <= gfftc_pkg::CFG_DIM_RESET;
      cols_reg <= gfftc_pkg::CFG_DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gfftc_pkg::CFG_ROWS: rows_reg <= cfg_data;
        gfftc_pkg::CFG_COLS: cols_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      dir      <= gfftc_pkg::DIR_DOWN;
    end else begin
      if (q_we) tail <= tail + PW'(1);
      case (state)
        gfftc_pkg::ST_LOAD: begin
          if (accept && load_ok) load_pos <= load_pos + PW'(1);
        end
        gfftc_pkg::ST_INIT: begin
          // geometry in force at the last cell; unloaded cells stay out
          limit    <= (PW'(prod) < load_pos) ? PW'(prod) : load_pos;
          seed_end <= tail;
        end
        gfftc_pkg::ST_POP: begin
          if (head != tail) begin
            seed <= head < seed_end;
            head <= head + PW'(1);
          end
        end
        gfftc_pkg::ST_POPW: begin
          cur_p <= q_p;
          cur_c <= q_rdata[QW-1:AW];
        end
        gfftc_pkg::ST_REM: begin
          if (rem_done) cur_c <= CW'(rem_value);
        end
        gfftc_pkg::ST_CURW: begin
          if (c_rdata[1:0] == gfftc_pkg::KIND_TARGET && count != gfftc_pkg::COUNT_MAX) begin
            count <= count + gfftc_pkg::COUNT_W'(1);
          end
          dir <= gfftc_pkg::DIR_DOWN;
        end
        gfftc_pkg::ST_NB: begin
          nb_p <= np_s[AW-1:0];
          nb_c <= nc;
          if (!nb_ok) dir <= gfftc_pkg::next_dir(dir);
        end
        gfftc_pkg::ST_NBW: dir <= gfftc_pkg::next_dir(dir);
        gfftc_pkg::ST_DONE: begin
          load_pos <= '0;
          head     <= '0;
          tail     <= '0;
          count    <= '0;
        end
        default: ;
      endcase
    end
  end

  gfftc_ram #(.DEPTH(CAP), .WIDTH(3), .AW(AW)) u_cell_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (c_re),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  gfftc_ram #(.DEPTH(CAP), .WIDTH(QW), .AW(AW)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // column of a start cell is recovered from its position
  gfftc_rem #(.DW(AW), .RW(CW1)) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (q_p),
    .divisor   (cols_c),
    .done      (rem_done),
    .remainder (rem_value)
  );

  a_head_le_tail: assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("queue head passed tail");
  a_tail_cap: assert property (@(posedge clk) disable iff (rst) tail <= CAP_P)
    else $error("queue overflow");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last_cell) |=> busy)
    else $error("last cell did not start the fill");

endmodule
`default_nettype wire

// File: rtl/gfftc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfftc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gfftc_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 3,
  parameter int AW    = 12
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/gfftc_rem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfftc_rem
// Serial remainder unit: dividend mod divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gfftc_rem #(
  parameter int DW = 12,
  parameter int RW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [RW-1:0] divisor,
  output logic               done,
  output logic      [RW-1:0] remainder
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    dvd;
  logic [RW:0]      trial;

  assign trial = {remainder, dvd[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running   <= 1'b1;
        cnt       <= CNT_W'(DW);
        dvd       <= dividend;
        remainder <= '0;
      end else if (running) begin
        if (trial >= {1'b0, divisor}) begin
          remainder <= RW'(trial - {1'b0, divisor});
        end else begin
          remainder <= trial[RW-1:0];
        end
        dvd <= dvd << 1;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flood-fill target counter testbench
// Streams classified grids into the core one cell per request and predicts
// each reachable-target count with a local breadth-first fill over its own
// copy of the grid. Directed cases cover dimension clamping, early and
// oversized grids and a resize mid-load; random grids run with bursty or steady start.
// ----------------------------------------------------------------------------
module testbench;

  localparam int GRID_CAP      = 64 * 64;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_CELLS  = 1250;
  localparam int MAX_REPORTS   = 10;

  localparam logic [1:0] KIND_OPEN = 2'd1;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            start = 1'b0;
  logic                            busy;
  logic [1:0]                      cell_kind = gfftc_pkg::KIND_BLOCKED;
  logic                            last_cell = 1'b0;
  logic                            done;
  logic [gfftc_pkg::COUNT_W-1:0]   target_count;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [gfftc_pkg::CFG_IDX_W-1:0] cfg_index = gfftc_pkg::CFG_ROWS;
  logic [gfftc_pkg::CFG_W-1:0]     cfg_data = '0;

  // local copy of the grid, visit marks and frontier
  logic [1:0]                    cell_mem [GRID_CAP];
  bit                            reached_mem [GRID_CAP];
  int unsigned                   frontier [GRID_CAP];
  int unsigned                   q_head = 0;
  int unsigned                   q_tail = 0;
  int unsigned                   load_pos = 0;
  logic [gfftc_pkg::CFG_W-1:0]   rows_reg = gfftc_pkg::CFG_DIM_RESET;
  logic [gfftc_pkg::CFG_W-1:0]   cols_reg = gfftc_pkg::CFG_DIM_RESET;
  logic [gfftc_pkg::COUNT_W-1:0] expected_counts [$];

  int unsigned cells_sent = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  int unsigned counts_seen = 0;
  int          mismatches = 0;
  bit          bursty = 1'b1;

  always #5 clk = ~clk;

  grid_flood_fill_target_counter_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cell_kind    (cell_kind),
    .last_cell    (last_cell),
    .done         (done),
    .target_count (target_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  function automatic int unsigned clamp_dim(input logic [gfftc_pkg::CFG_W-1:0] v,
                                            input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic void mark_reached(input int unsigned pos, input int unsigned span);
    if (pos < span && cell_mem[pos] != gfftc_pkg::KIND_BLOCKED && !reached_mem[pos]) begin
      reached_mem[pos] = 1'b1;
      if (q_tail < GRID_CAP) begin
        frontier[q_tail] = pos;
        q_tail++;
      end
    end
  endfunction

  function automatic logic [gfftc_pkg::COUNT_W-1:0] flood_count();
    int unsigned nrows, ncols, span, pos, r, c;
    logic [gfftc_pkg::COUNT_W-1:0] total;
    nrows = clamp_dim(rows_reg, 64);
    ncols = clamp_dim(cols_reg, 64);
    span  = nrows * ncols;
    if (load_pos < span) span = load_pos;
    total = '0;
    while (q_head < q_tail) begin
      pos = frontier[q_head];
      q_head++;
      // starts beyond the loaded / configured area are dropped
      if (pos < span) begin
        if (cell_mem[pos] == gfftc_pkg::KIND_TARGET && total < gfftc_pkg::COUNT_MAX) total++;
        r = pos / ncols;
        c = pos % ncols;
        if (r + 1 < nrows) mark_reached(pos + ncols, span);
        if (r > 0)         mark_reached(pos - ncols, span);
        if (c + 1 < ncols) mark_reached(pos + 1, span);
        if (c > 0)         mark_reached(pos - 1, span);
      end
    end
    return total;
  endfunction

  function automatic void absorb_cell(input logic [1:0] kind, input logic last);
    if (load_pos < GRID_CAP) begin
      cell_mem[load_pos]    = kind;
      reached_mem[load_pos] = (kind == gfftc_pkg::KIND_START);
      if (kind == gfftc_pkg::KIND_START && q_tail < GRID_CAP) begin
        frontier[q_tail] = load_pos;
        q_tail++;
      end
      load_pos++;
    end
    if (last) begin
      expected_counts.push_back(flood_count());
      q_head   = 0;
      q_tail   = 0;
      load_pos = 0;
    end
  endfunction

  function automatic void note_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    logic [gfftc_pkg::COUNT_W-1:0] want;
    if (!rst && done === 1'b1) begin
      counts_seen++;
      if (expected_counts.size() == 0) begin
        note_error($sformatf("count %0d: unexpected result, target_count %0d",
                             counts_seen, target_count));
      end else begin
        want = expected_counts.pop_front();
        if (target_count !== want)
          note_error($sformatf("count %0d: target_count expected %0d, got %0d",
                               counts_seen, want, target_count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_cell(input logic [1:0] kind, input logic last);
    int unsigned gap;
    if (bursty) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(0, 5);
        repeat (gap) begin
          @(negedge clk);
          start     = 1'b0;
          cell_kind = 2'($urandom);
          last_cell = 1'($urandom);
        end
      end
      burst_left--;
    end
    @(negedge clk);
    start     = 1'b1;
    cell_kind = kind;
    last_cell = last;
    do @(posedge clk); while (busy !== 1'b0);
    absorb_cell(kind, last);
    cells_sent++;
  endtask

  // drop start, wait for outstanding counts, then give the core time to go idle
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gfftc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gfftc_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == gfftc_pkg::CFG_ROWS) rows_reg = val;
    else cols_reg = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_geometry(input logic [gfftc_pkg::CFG_W-1:0] r,
                              input logic [gfftc_pkg::CFG_W-1:0] c);
    settle();
    write_reg(gfftc_pkg::CFG_ROWS, r);
    write_reg(gfftc_pkg::CFG_COLS, c);
  endtask

  function automatic logic [1:0] random_kind(input int unsigned wall);
    int unsigned x;
    x = $urandom_range(0, 99);
    if (x < wall) return gfftc_pkg::KIND_BLOCKED;
    if (x < wall + 8) return gfftc_pkg::KIND_START;
    if (x < wall + 25) return gfftc_pkg::KIND_TARGET;
    return KIND_OPEN;
  endfunction

  task automatic random_grid(input int unsigned n, input int unsigned wall_max);
    int unsigned wall;
    wall = $urandom_range(0, wall_max);
    for (int unsigned i = 0; i < n; i++)
      send_cell(random_kind(wall), i == n - 1);
  endtask

  function automatic logic [gfftc_pkg::CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return 7'd0;
      1:       return 7'd127;
      2:       return 7'd64;
      3:       return 7'd65;
      4, 5:    return 7'd1;
      default: return gfftc_pkg::CFG_W'($urandom_range(2, 10));
    endcase
  endfunction

  // reset geometry is 64x64; a three-cell grid ends early, reach to the right
  task automatic test_reset_geometry();
    send_cell(gfftc_pkg::KIND_START, 1'b0);
    send_cell(KIND_OPEN, 1'b0);
    send_cell(gfftc_pkg::KIND_TARGET, 1'b1);
  endtask

  task automatic test_clamped_dims();
    // zero acts as one: the start past the 1x1 area is dropped
    set_geometry(7'd0, 7'd0);
    send_cell(KIND_OPEN, 1'b0);
    send_cell(gfftc_pkg::KIND_START, 1'b1);
    // 64x1 column, target above the start
    set_geometry(7'd127, 7'd1);
    send_cell(gfftc_pkg::KIND_TARGET, 1'b0);
    send_cell(KIND_OPEN, 1'b0);
    send_cell(gfftc_pkg::KIND_START, 1'b1);
    // 1x64 row, wall on the left side
    set_geometry(7'd1, 7'd127);
    send_cell(gfftc_pkg::KIND_TARGET, 1'b0);
    send_cell(gfftc_pkg::KIND_BLOCKED, 1'b0);
    send_cell(gfftc_pkg::KIND_START, 1'b0);
    send_cell(KIND_OPEN, 1'b0);
    send_cell(gfftc_pkg::KIND_TARGET, 1'b1);
  endtask

  task automatic test_all_kinds();
    set_geometry(7'd2, 7'd2);
    send_cell(gfftc_pkg::KIND_TARGET, 1'b0);
    send_cell(gfftc_pkg::KIND_START, 1'b0);
    send_cell(gfftc_pkg::KIND_BLOCKED, 1'b0);
    send_cell(gfftc_pkg::KIND_TARGET, 1'b1);
  endtask

  // geometry in force at the last cell decides the fill
  task automatic test_midgrid_resize();
    set_geometry(7'd1, 7'd1);
    send_cell(gfftc_pkg::KIND_START, 1'b0);
    send_cell(KIND_OPEN, 1'b0);
    settle();
    write_reg(gfftc_pkg::CFG_ROWS, 7'd2);
    write_reg(gfftc_pkg::CFG_COLS, 7'd2);
    send_cell(KIND_OPEN, 1'b0);
    send_cell(gfftc_pkg::KIND_TARGET, 1'b1);
  endtask

  task automatic test_random_grids();
    int unsigned stop_at, area, n;
    logic [gfftc_pkg::CFG_W-1:0] r, c;
    stop_at = cells_sent + RANDOM_CELLS;
    while (cells_sent < stop_at) begin
      bursty = ($urandom_range(0, 3) != 0);
      r = pick_dim();
      c = pick_dim();
      set_geometry(r, c);
      area = clamp_dim(r, 64) * clamp_dim(c, 64);
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 9))
          0:       n = $urandom_range(1, area);
          1:       n = area + $urandom_range(1, 6);
          default: n = area;
        endcase
        if (n > 120) n = $urandom_range(1, 120);
        random_grid(n, 50);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_geometry();
    test_clamped_dims();
    test_all_kinds();
    test_midgrid_resize();
    test_random_grids();
    settle();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && expected_counts.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
